// File: sv/pcm_byte_stream_unpacker_macros.svh
// Assertion macros for the PCM byte-stream unpacker.
// No dependencies; included by files that carry concurrent checks.
`ifndef PCM_BYTE_STREAM_UNPACKER_MACROS_SVH
`define PCM_BYTE_STREAM_UNPACKER_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge out of reset.
`define PBSU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true out of reset.
`define PBSU_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define PBSU_ASSERT(lbl, clk, rst_n, prop, msg)
`define PBSU_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: sv/pbsu_pkg.sv
// Shared types and helpers for the PCM byte-stream unpacker.
// No dependencies; used by pbsu_decode and pcm_byte_stream_unpacker.
package pbsu_pkg;

    localparam int unsigned FormatWidth = 5;
    localparam int unsigned WordWidth   = 64;

    typedef enum logic [FormatWidth-1:0] {
        FMT_U8     = 5'd0,
        FMT_S8     = 5'd1,
        FMT_SGA    = 5'd2,
        FMT_S16LE  = 5'd3,
        FMT_S16BE  = 5'd4,
        FMT_U16LE  = 5'd5,
        FMT_U16BE  = 5'd6,
        FMT_S24LE  = 5'd7,
        FMT_S24BE  = 5'd8,
        FMT_U24LE  = 5'd9,
        FMT_U24BE  = 5'd10,
        FMT_S24DC  = 5'd11,
        FMT_S32LE  = 5'd12,
        FMT_S32BE  = 5'd13,
        FMT_U32LE  = 5'd14,
        FMT_U32BE  = 5'd15,
        FMT_S64LE  = 5'd16,
        FMT_S64BE  = 5'd17,
        FMT_ALAW   = 5'd18,
        FMT_MULAW  = 5'd19,
        FMT_LXF    = 5'd20
    } t_format;

    typedef logic [WordWidth-1:0] t_word;

    // Bytes per coded sample; unused codes take one byte.
    function automatic logic [3:0] size_of(input logic [FormatWidth-1:0] f);
        logic [3:0] s;
        if (f <= FMT_SGA || f == FMT_ALAW || f == FMT_MULAW) begin
            s = 4'd1;
        end else if (f <= FMT_U16BE) begin
            s = 4'd2;
        end else if (f <= FMT_S24DC) begin
            s = 4'd3;
        end else if (f <= FMT_U32BE) begin
            s = 4'd4;
        end else if (f <= FMT_S64BE) begin
            s = 4'd8;
        end else if (f == FMT_LXF) begin
            s = 4'd5;
        end else begin
            s = 4'd1;
        end
        return s;
    endfunction

endpackage

// File: sv/pbsu_decode.sv
// Sample decoder: turns a gathered byte word into one or two result words.
// Depends on pbsu_pkg (format codes, word type).
module pbsu_decode (
    input  pbsu_pkg::t_word   i_gather,
    input  pbsu_pkg::t_format i_format,
    output pbsu_pkg::t_word   o_word0,
    output pbsu_pkg::t_word   o_word1,
    output logic [1:0]        o_count
);

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = b[i];
        end
        return r;
    endfunction

    logic [15:0] w16;
    logic [23:0] w24;
    logic [31:0] w32;
    logic [7:0]  a_byte;
    logic [15:0] a_mag;
    logic [7:0]  u_byte;
    logic [15:0] u_mag;
    logic [7:0]  sga_mag;

    always_comb begin
        o_word0 = '0;
        o_word1 = '0;
        o_count = 2'd0;
        w16     = '0;
        w24     = '0;
        w32     = '0;
        a_byte  = i_gather[7:0] ^ 8'h55;
        u_byte  = ~i_gather[7:0];
        sga_mag = {1'b0, i_gather[6:0]};
        // A-law: segment 0 has no implied leading one
        if (a_byte[6:4] != 3'd0) begin
            a_mag = 16'({1'b1, a_byte[3:0], 1'b1}) << ({1'b0, a_byte[6:4]} + 4'd2);
        end else begin
            a_mag = 16'({a_byte[3:0], 1'b1}) << 3;
        end
        // mu-law: biased magnitude, bias removed after the shift
        u_mag = (16'({u_byte[3:0], 3'b000}) + 16'h0084) << u_byte[6:4];

        case (i_format)
            pbsu_pkg::FMT_U8: begin
                o_word0 = {56'd0, i_gather[7:0]};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_S8: begin
                o_word0 = {56'd0, ~i_gather[7], i_gather[6:0]};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_SGA: begin
                o_word0 = {56'd0, (i_gather[7] ? (8'h80 - sga_mag) : (8'h80 + sga_mag))};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_S16LE, pbsu_pkg::FMT_S16BE,
            pbsu_pkg::FMT_U16LE, pbsu_pkg::FMT_U16BE: begin
                if (i_format == pbsu_pkg::FMT_S16BE || i_format == pbsu_pkg::FMT_U16BE) begin
                    w16 = {i_gather[7:0], i_gather[15:8]};
                end else begin
                    w16 = i_gather[15:0];
                end
                // offset removal modulo 2^16 is a flip of the top bit
                if (i_format >= pbsu_pkg::FMT_U16LE) begin
                    w16[15] = ~w16[15];
                end
                o_word0 = {48'd0, w16};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_S24LE, pbsu_pkg::FMT_S24BE,
            pbsu_pkg::FMT_U24LE, pbsu_pkg::FMT_U24BE: begin
                if (i_format == pbsu_pkg::FMT_S24BE || i_format == pbsu_pkg::FMT_U24BE) begin
                    w24 = {i_gather[7:0], i_gather[15:8], i_gather[23:16]};
                end else begin
                    w24 = i_gather[23:0];
                end
                if (i_format >= pbsu_pkg::FMT_U24LE) begin
                    w24[23] = ~w24[23];
                end
                o_word0 = {32'd0, w24, 8'd0};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_S24DC: begin
                // big-endian 24 bits, top 4 and bottom 4 bits dropped, each byte bit-reversed
                w24     = {i_gather[7:0], i_gather[15:8], i_gather[23:16]};
                o_word0 = {48'd0, rev8(w24[11:4]), rev8(w24[19:12])};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_S32LE, pbsu_pkg::FMT_S32BE,
            pbsu_pkg::FMT_U32LE, pbsu_pkg::FMT_U32BE: begin
                if (i_format == pbsu_pkg::FMT_S32BE || i_format == pbsu_pkg::FMT_U32BE) begin
                    w32 = {i_gather[7:0], i_gather[15:8], i_gather[23:16], i_gather[31:24]};
                end else begin
                    w32 = i_gather[31:0];
                end
                if (i_format >= pbsu_pkg::FMT_U32LE) begin
                    w32[31] = ~w32[31];
                end
                o_word0 = {32'd0, w32};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_S64LE: begin
                o_word0 = i_gather;
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_S64BE: begin
                o_word0 = {i_gather[7:0],   i_gather[15:8],  i_gather[23:16], i_gather[31:24],
                           i_gather[39:32], i_gather[47:40], i_gather[55:48], i_gather[63:56]};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_ALAW: begin
                o_word0 = {48'd0, (a_byte[7] ? a_mag : (16'd0 - a_mag))};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_MULAW: begin
                o_word0 = {48'd0, (u_byte[7] ? (16'h0084 - u_mag) : (u_mag - 16'h0084))};
                o_count = 2'd1;
            end
            pbsu_pkg::FMT_LXF: begin
                // five bytes carry two 20-bit samples
                o_word0 = {32'd0, i_gather[19:16], i_gather[15:8], i_gather[7:0],
                           i_gather[19:16], i_gather[15:8]};
                o_word1 = {32'd0, i_gather[39:32], i_gather[31:24], i_gather[23:20],
                           i_gather[39:32], i_gather[31:28]};
                o_count = 2'd2;
            end
            default: begin
                o_count = 2'd0;
            end
        endcase
    end

endmodule

// File: sv/pcm_byte_stream_unpacker.sv
// PCM byte-stream unpacker: one byte per transfer in, decoded samples out.
// A byte that completes a sample is registered in the completed-sample register, then decoded into the result register.
// Throughput: 1 byte per cycle while no completed sample waits on a busy result register.
// LXF gives two results on its fifth byte; they leave in order, word 0 first.
// Reset (synchronous, active low): format U8, gather and count cleared, pipeline empty.
// Depends on pbsu_pkg, pbsu_decode and pcm_byte_stream_unpacker_macros.svh.
`include "pcm_byte_stream_unpacker_macros.svh"

module pcm_byte_stream_unpacker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_sample_word,
    output logic        o_last_of_run,
    // format register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_format
);

    // ---------------------------------------------------------------
    // Gather state: bytes of the sample in progress, first byte at [7:0]
    // ---------------------------------------------------------------
    logic [4:0]       r_format;
    pbsu_pkg::t_word  r_gather, n_gather;
    logic [2:0]       r_count,  n_count;

    // Completed-sample register (decoder input)
    logic              r_s1_valid, n_s1_valid;
    pbsu_pkg::t_word   r_s1_gather;
    pbsu_pkg::t_format r_s1_format;

    // Result register: up to two words, head in r_o_w0
    logic [1:0]        r_o_cnt, n_o_cnt;
    pbsu_pkg::t_word   r_o_w0, n_o_w0;
    pbsu_pkg::t_word   r_o_w1, n_o_w1;

    logic              in_xfer;
    logic              out_xfer;
    logic              cfg_xfer;
    logic              complete;
    logic              fmt_used;
    logic              s1_load;
    logic              s1_move;
    logic              s2_free;
    pbsu_pkg::t_word   gather_new;
    pbsu_pkg::t_word   dec_w0;
    pbsu_pkg::t_word   dec_w1;
    logic [1:0]        dec_cnt;

    // Register writes are only to be made while idle; the block does not enforce it and always takes them.
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;

    assign in_xfer  = i_in_valid & o_in_ready;
    assign out_xfer = o_out_valid & i_out_ready;

    // Byte lands at the lane given by the current count.
    assign gather_new = r_gather | (pbsu_pkg::t_word'(i_data_byte) << {r_count, 3'b000});
    assign complete   = ({1'b0, r_count} + 4'd1) >= pbsu_pkg::size_of(r_format);
    // Codes past LXF swallow bytes without a result.
    assign fmt_used   = r_format <= pbsu_pkg::FMT_LXF;
    assign s1_load    = in_xfer & complete & fmt_used;

    // Result register takes a new sample when empty or when its last word leaves now.
    assign s2_free = (r_o_cnt == 2'd0) | ((r_o_cnt == 2'd1) & i_out_ready);
    assign s1_move = r_s1_valid & s2_free;

    // Byte input stalls only while a completed sample cannot move on.
    assign o_in_ready = ~r_s1_valid | s1_move;

    // ---------------------------------------------------------------
    // Gather next state
    // ---------------------------------------------------------------
    always_comb begin
        n_gather = r_gather;
        n_count  = r_count;
        if (cfg_xfer) begin
            n_gather = '0;
            n_count  = 3'd0;
        end else if (in_xfer) begin
            if (complete || i_end_of_packet) begin
                // sample done, or partial sample dropped at end of packet
                n_gather = '0;
                n_count  = 3'd0;
            end else begin
                n_gather = gather_new;
                n_count  = r_count + 3'd1;
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_load) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Decoder between the completed-sample and result registers
    // ---------------------------------------------------------------
    pbsu_decode u_decode (
        .i_gather (r_s1_gather),
        .i_format (r_s1_format),
        .o_word0  (dec_w0),
        .o_word1  (dec_w1),
        .o_count  (dec_cnt)
    );

    always_comb begin
        n_o_cnt = r_o_cnt;
        n_o_w0  = r_o_w0;
        n_o_w1  = r_o_w1;
        if (s1_move) begin
            n_o_cnt = dec_cnt;
            n_o_w0  = dec_w0;
            n_o_w1  = dec_w1;
        end else if (out_xfer) begin
            n_o_cnt = r_o_cnt - 2'd1;
            n_o_w0  = r_o_w1;
        end
    end

    assign o_out_valid   = r_o_cnt != 2'd0;
    assign o_sample_word = r_o_w0;
    assign o_last_of_run = r_o_cnt == 2'd1;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format   <= 5'(pbsu_pkg::FMT_U8);
            r_gather   <= '0;
            r_count    <= 3'd0;
            r_s1_valid <= 1'b0;
            r_o_cnt    <= 2'd0;
        end else begin
            if (cfg_xfer) begin
                r_format <= i_cfg_format;
            end
            r_gather   <= n_gather;
            r_count    <= n_count;
            r_s1_valid <= n_s1_valid;
            r_o_cnt    <= n_o_cnt;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_gather <= gather_new;
            r_s1_format <= pbsu_pkg::t_format'(r_format);
        end
        r_o_w0 <= n_o_w0;
        r_o_w1 <= n_o_w1;
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `PBSU_NEVER(a_count_in_range, i_clk, i_rst_n, {1'b0, r_count} >= pbsu_pkg::size_of(r_format), "gather count reached sample size")
    `PBSU_ASSERT(a_eop_clears, i_clk, i_rst_n, (in_xfer && i_end_of_packet) |=> (r_count == 3'd0 && r_gather == '0), "partial sample survived end of packet")
    `PBSU_ASSERT(a_s1_holds, i_clk, i_rst_n, (r_s1_valid && !s2_free) |=> (r_s1_valid && $stable(r_s1_gather)), "completed sample lost while result register busy")
    `PBSU_NEVER(a_cnt_max, i_clk, i_rst_n, r_o_cnt == 2'd3, "result register holds more than two words")

endmodule
